// ===== rtl/mmtq_pkg.sv =====
`timescale 1ns / 1ps

package mmtq_pkg;

    // Command codes carried on the opcode field
    localparam logic [2:0] OP_RAW     = 3'd0;
    localparam logic [2:0] OP_NOTE_ON = 3'd1;
    localparam logic [2:0] OP_NOTE_OFF = 3'd2;
    localparam logic [2:0] OP_PROGRAM = 3'd3;
    localparam logic [2:0] OP_CONTROL = 3'd4;
    localparam logic [2:0] OP_BEND    = 3'd5;
    localparam logic [2:0] OP_GM_ON   = 3'd6;
    localparam logic [2:0] OP_DRAIN   = 3'd7;

    // MIDI status nibbles and fixed bytes
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] ST_CONTROL  = 8'hB0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] SYSEX_START = 8'hF0;
    localparam logic [7:0] SYSEX_NONRT = 8'h7E;
    localparam logic [7:0] SYSEX_ALL   = 8'h7F;
    localparam logic [7:0] SYSEX_GM    = 8'h09;
    localparam logic [7:0] SYSEX_GM_ON = 8'h01;
    localparam logic [7:0] SYSEX_END   = 8'hF7;

    // Ring queue default size and device FIFO limits
    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int TX_FIFO_DEPTH   = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int ROOM_LIMIT      = (TX_FIFO_DEPTH < MAX_RESULTS) ? TX_FIFO_DEPTH
                                                                   : MAX_RESULTS;
    localparam logic [4:0] ROOM_MAX = 5'(ROOM_LIMIT);

    localparam int MSG_BYTES = 6;

    typedef logic [9:0]  level_t;
    typedef logic [15:0] drop_t;
    typedef logic [4:0]  room_t;

    // One classified command as handed from the front to the back
    typedef struct packed {
        logic                       drain;
        logic [2:0]                 count;
        logic [MSG_BYTES-1:0][7:0]  bytes;
        room_t                      room;
    } cmd_t;

endpackage

// ===== rtl/mmtq_front.sv =====
`timescale 1ns / 1ps

module mmtq_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                enable,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          opcode,
    input  logic [7:0]          raw_byte,
    input  logic [3:0]          channel,
    input  logic [6:0]          key,
    input  logic [13:0]         amount,
    input  logic [4:0]          tx_free,
    output logic                cmd_push,
    output mmtq_pkg::cmd_t      cmd_data,
    input  logic                cmd_full
);

    logic enable_reg;
    logic enable_next;
    logic [7:0] vel;

    // Hold the enable register
    assign cfg_ready   = 1'b1;
    assign enable_next = (cfg_valid && cfg_ready) ? enable : enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else
        begin
            enable_reg <= enable_next;
        end
    end

    // Accept a transaction whenever the command queue has room
    assign in_ready = !cmd_full;
    assign cmd_push = in_valid && in_ready;
    assign vel      = {1'b0, amount[6:0]};

    // Expand the command into its message bytes
    always_comb
    begin
        cmd_data.drain = 1'b0;
        cmd_data.count = 3'd0;
        cmd_data.bytes = '0;
        cmd_data.room  = (tx_free > mmtq_pkg::ROOM_MAX) ? mmtq_pkg::ROOM_MAX : tx_free;
        if (enable_reg)
        begin
            unique case (opcode)
                mmtq_pkg::OP_RAW:
                begin
                    cmd_data.count    = 3'd1;
                    cmd_data.bytes[0] = raw_byte;
                end
                mmtq_pkg::OP_NOTE_ON:
                begin
                    cmd_data.count    = 3'd3;
                    cmd_data.bytes[0] = mmtq_pkg::ST_NOTE_ON | {4'd0, channel};
                    cmd_data.bytes[1] = {1'b0, key};
                    cmd_data.bytes[2] = vel;
                end
                mmtq_pkg::OP_NOTE_OFF:
                begin
                    cmd_data.count    = 3'd3;
                    cmd_data.bytes[0] = mmtq_pkg::ST_NOTE_OFF | {4'd0, channel};
                    cmd_data.bytes[1] = {1'b0, key};
                    cmd_data.bytes[2] = 8'd0;
                end
                mmtq_pkg::OP_PROGRAM:
                begin
                    cmd_data.count    = 3'd2;
                    cmd_data.bytes[0] = mmtq_pkg::ST_PROGRAM | {4'd0, channel};
                    cmd_data.bytes[1] = {1'b0, key};
                end
                mmtq_pkg::OP_CONTROL:
                begin
                    cmd_data.count    = 3'd3;
                    cmd_data.bytes[0] = mmtq_pkg::ST_CONTROL | {4'd0, channel};
                    cmd_data.bytes[1] = {1'b0, key};
                    cmd_data.bytes[2] = vel;
                end
                mmtq_pkg::OP_BEND:
                begin
                    cmd_data.count    = 3'd3;
                    cmd_data.bytes[0] = mmtq_pkg::ST_BEND | {4'd0, channel};
                    cmd_data.bytes[1] = vel;
                    cmd_data.bytes[2] = {1'b0, amount[13:7]};
                end
                mmtq_pkg::OP_GM_ON:
                begin
                    cmd_data.count    = 3'd6;
                    cmd_data.bytes[0] = mmtq_pkg::SYSEX_START;
                    cmd_data.bytes[1] = mmtq_pkg::SYSEX_NONRT;
                    cmd_data.bytes[2] = mmtq_pkg::SYSEX_ALL;
                    cmd_data.bytes[3] = mmtq_pkg::SYSEX_GM;
                    cmd_data.bytes[4] = mmtq_pkg::SYSEX_GM_ON;
                    cmd_data.bytes[5] = mmtq_pkg::SYSEX_END;
                end
                mmtq_pkg::OP_DRAIN:
                begin
                    cmd_data.drain = 1'b1;
                end
                default:
                begin
                    cmd_data.drain = 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/mmtq_cmd_fifo.sv =====
`timescale 1ns / 1ps

module mmtq_cmd_fifo
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmtq_pkg::cmd_t      push_data,
    output logic                full,
    input  logic                pop,
    output mmtq_pkg::cmd_t      pop_data,
    output logic                empty
);

    mmtq_pkg::cmd_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/mmtq_back.sv =====
`timescale 1ns / 1ps

module mmtq_back
#(
    parameter int QUEUE_DEPTH = mmtq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_empty,
    input  mmtq_pkg::cmd_t      cmd_data,
    output logic                cmd_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          tx_byte,
    output logic                byte_valid,
    output logic                last,
    output logic [9:0]          queue_level,
    output logic [15:0]         drop_total
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEND     = 3'd1;
    localparam logic [2:0] S_DRAIN_RD = 3'd2;
    localparam logic [2:0] S_DRAIN_EM = 3'd3;
    localparam logic [2:0] S_STATUS   = 3'd4;

    logic [7:0] queue_mem [QUEUE_DEPTH];
    logic [7:0] rd_data_reg;

    logic [2:0]            state_reg, state_next;
    mmtq_pkg::cmd_t        cmd_reg, cmd_next;
    logic [2:0]            idx_reg, idx_next;
    mmtq_pkg::room_t       room_reg, room_next;
    logic                  emitted_reg, emitted_next;
    logic [PTR_W-1:0]      wp_reg, wp_next;
    logic [PTR_W-1:0]      rp_reg, rp_next;
    logic [PTR_W-1:0]      level_reg, level_next;
    mmtq_pkg::drop_t       drop_reg, drop_next;

    logic                  out_valid_reg;
    logic [7:0]            tx_byte_reg, tx_byte_next;
    logic                  byte_valid_reg, byte_valid_next;
    logic                  last_reg, last_next;
    mmtq_pkg::level_t      level_out_reg, level_out_next;
    mmtq_pkg::drop_t       drop_out_reg;

    logic                  out_free;
    logic                  out_load;
    logic                  mem_we;
    logic                  mem_re;
    logic                  advance;
    logic                  last_byte;
    logic [7:0]            cur_byte;

    assign out_free  = !out_valid_reg || out_ready;
    assign last_byte = (idx_reg == (cmd_reg.count - 3'd1));
    assign cur_byte  = cmd_reg.bytes[idx_reg];

    // Sequence message bytes and drain ticks
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        room_next       = room_reg;
        emitted_next    = emitted_reg;
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        level_next      = level_reg;
        drop_next       = drop_reg;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        advance         = 1'b0;
        out_load        = 1'b0;
        tx_byte_next    = cur_byte;
        byte_valid_next = 1'b1;
        last_next       = 1'b1;
        level_out_next  = mmtq_pkg::level_t'(level_reg);
        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop      = 1'b1;
                    cmd_next     = cmd_data;
                    idx_next     = 3'd0;
                    room_next    = cmd_data.room;
                    emitted_next = 1'b0;
                    if (cmd_data.drain)
                    begin
                        state_next = S_DRAIN_RD;
                    end
                    else if (cmd_data.count != 3'd0)
                    begin
                        state_next = S_SEND;
                    end
                    else
                    begin
                        state_next = S_STATUS;
                    end
                end
            end
            S_SEND:
            begin
                if (level_reg == '0 && room_reg != '0)
                begin
                    // Pass the byte straight to the device
                    if (out_free)
                    begin
                        out_load     = 1'b1;
                        last_next    = last_byte || (room_reg == 5'd1);
                        room_next    = room_reg - 5'd1;
                        emitted_next = 1'b1;
                        advance      = 1'b1;
                    end
                end
                else if (level_reg == PTR_LAST)
                begin
                    // Drop on a full ring, count saturates
                    if (drop_reg != 16'hFFFF)
                    begin
                        drop_next = drop_reg + 16'd1;
                    end
                    advance = 1'b1;
                end
                else
                begin
                    mem_we     = 1'b1;
                    wp_next    = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
                    level_next = level_reg + 1'b1;
                    advance    = 1'b1;
                end
                if (advance)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (last_byte)
                    begin
                        state_next = emitted_next ? S_IDLE : S_STATUS;
                    end
                end
            end
            S_DRAIN_RD:
            begin
                if (level_reg == '0 || room_reg == '0)
                begin
                    state_next = emitted_reg ? S_IDLE : S_STATUS;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_DRAIN_EM;
                end
            end
            S_DRAIN_EM:
            begin
                if (out_free)
                begin
                    out_load       = 1'b1;
                    tx_byte_next   = rd_data_reg;
                    last_next      = (level_reg == PTR_W'(1)) || (room_reg == 5'd1);
                    rp_next        = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
                    level_next     = level_reg - 1'b1;
                    level_out_next = mmtq_pkg::level_t'(level_next);
                    room_next      = room_reg - 5'd1;
                    emitted_next   = 1'b1;
                    state_next     = last_next ? S_IDLE : S_DRAIN_RD;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    tx_byte_next    = 8'd0;
                    byte_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= 3'd0;
            room_reg      <= '0;
            emitted_reg   <= 1'b0;
            wp_reg        <= '0;
            rp_reg        <= '0;
            level_reg     <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            room_reg      <= room_next;
            emitted_reg   <= emitted_next;
            wp_reg        <= wp_next;
            rp_reg        <= rp_next;
            level_reg     <= level_next;
            drop_reg      <= drop_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the command and the result payload
    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (out_load)
        begin
            tx_byte_reg    <= tx_byte_next;
            byte_valid_reg <= byte_valid_next;
            last_reg       <= last_next;
            level_out_reg  <= level_out_next;
            drop_out_reg   <= drop_reg;
        end
    end

    // Ring queue storage, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            queue_mem[wp_reg] <= cur_byte;
        end
        if (mem_re)
        begin
            rd_data_reg <= queue_mem[rp_reg];
        end
    end

    assign out_valid   = out_valid_reg;
    assign tx_byte     = tx_byte_reg;
    assign byte_valid  = byte_valid_reg;
    assign last        = last_reg;
    assign queue_level = level_out_reg;
    assign drop_total  = drop_out_reg;

endmodule

// ===== rtl/midi_message_tx_queue.sv =====
`timescale 1ns / 1ps

// MIDI transmit queue.
// Input channel (in_valid/in_ready): one command per transaction: raw byte,
// note on/off, program, control, pitch bend, GM system on, or drain tick,
// with tx_free giving the room in the device FIFO for that command.
// Output channel (out_valid/out_ready): one transaction per byte written to
// the device, or a single status transaction (byte_valid 0) when no byte
// goes out; last marks the final transaction of each command.
// Config channel (cfg_valid/cfg_ready, data on enable): write only while idle.
// A command passes through the command queue to the back end, which fetches
// one command at a time, then handles each message byte in turn and drains
// each ring byte with a ring memory read followed by an emit. All results
// leave through the registered result stage.
// A two-entry command queue lets new commands enter while the back end works.
// Reset clears enable, the ring pointers, level and the drop counter; the
// ring memory itself is not cleared and needs no clearing pass.
// When the receiver stalls, the result register holds and the sequencer
// waits; further commands collect in the command queue, then in_ready drops.
module midi_message_tx_queue
#(
    parameter int QUEUE_DEPTH = mmtq_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         enable,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [2:0]   opcode,
    input  logic [7:0]   raw_byte,
    input  logic [3:0]   channel,
    input  logic [6:0]   key,
    input  logic [13:0]  amount,
    input  logic [4:0]   tx_free,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [7:0]   tx_byte,
    output logic         byte_valid,
    output logic         last,
    output logic [9:0]   queue_level,
    output logic [15:0]  drop_total
);

    mmtq_pkg::cmd_t push_data;
    mmtq_pkg::cmd_t pop_data;
    logic           cmd_push;
    logic           cmd_pop;
    logic           cmd_full;
    logic           cmd_empty;

    mmtq_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .enable    (enable),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .raw_byte  (raw_byte),
        .channel   (channel),
        .key       (key),
        .amount    (amount),
        .tx_free   (tx_free),
        .cmd_push  (cmd_push),
        .cmd_data  (push_data),
        .cmd_full  (cmd_full)
    );

    mmtq_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (push_data),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (pop_data),
        .empty     (cmd_empty)
    );

    mmtq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_empty   (cmd_empty),
        .cmd_data    (pop_data),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .tx_byte     (tx_byte),
        .byte_valid  (byte_valid),
        .last        (last),
        .queue_level (queue_level),
        .drop_total  (drop_total)
    );

    // A status transaction always closes its command and carries no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> last && (tx_byte == 8'd0))
        else $error("status result without last or with data");

    // The back end never pops an empty command queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> !cmd_empty)
        else $error("command popped from empty queue");

    // The front end never pushes into a full command queue
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !cmd_full)
        else $error("command pushed into full queue");

endmodule
